// ----- rtl/bwd_pkg.sv -----
// Shared definitions for the Bayesian wall detector: register indexes,
// the sequencer state type and the status record of the serial units.
// Depends on nothing; every other file of the block imports it.
package bwd_pkg;

  localparam int LIMIT_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_USE_BAYES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_GIVEN_WALL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_GIVEN_OPEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_CONFIDENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_CONFIDENT = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_NEXT,
    S_DECIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ----- rtl/bwd_mul.sv -----
// Bit-serial multiplier pair for the Bayes update: forms lik_a*wt_a and
// lik_a*wt_a + lik_b*wt_b, one multiplier bit per cycle.
// Depends on bwd_pkg for the unit status record.
module bwd_mul #(
  parameter int PROB_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [PROB_FRAC_BITS:0]     lik_a,
  input  logic [PROB_FRAC_BITS:0]     lik_b,
  input  logic [PROB_FRAC_BITS:0]     wt_a,
  input  logic [PROB_FRAC_BITS:0]     wt_b,
  output logic [2*PROB_FRAC_BITS:0]   num,
  output logic [2*PROB_FRAC_BITS:0]   den,
  output bwd_pkg::unit_status_t       status
);
  import bwd_pkg::*;

  localparam int PW     = PROB_FRAC_BITS + 1;
  localparam int PROD_W = 2 * PROB_FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(PW);

  logic [PROD_W-1:0] sa;
  logic [PROD_W-1:0] sb;
  logic [PW-1:0]     ma;
  logic [PW-1:0]     mb;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [PROD_W-1:0] term_a;
  logic [PROD_W-1:0] term_b;

  assign term_a = ma[0] ? sa : '0;
  assign term_b = mb[0] ? sb : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // The denominator never exceeds one in Q1.2F, so it fits the product width.
  always_ff @(posedge clk) begin
    if (start) begin
      sa  <= PROD_W'(lik_a);
      sb  <= PROD_W'(lik_b);
      ma  <= wt_a;
      mb  <= wt_b;
      num <= '0;
      den <= '0;
    end else if (busy) begin
      num <= num + term_a;
      den <= den + term_a + term_b;
      sa  <= sa << 1;
      sb  <= sb << 1;
      ma  <= ma >> 1;
      mb  <= mb >> 1;
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// ----- rtl/bwd_div.sv -----
// Radix-2 restoring divider: one quotient bit per cycle, giving
// floor(num * 2^F / den) for num no greater than den.
// Depends on bwd_pkg for the unit status record.
module bwd_div #(
  parameter int PROB_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2*PROB_FRAC_BITS:0]   num,
  input  logic [2*PROB_FRAC_BITS:0]   den,
  output logic [PROB_FRAC_BITS:0]     quo,
  output bwd_pkg::unit_status_t       status
);
  import bwd_pkg::*;

  localparam int PW     = PROB_FRAC_BITS + 1;
  localparam int PROD_W = 2 * PROB_FRAC_BITS + 1;
  localparam int REM_W  = 2 * PROB_FRAC_BITS + 2;
  localparam int CNT_W  = $clog2(PW);

  logic [REM_W-1:0]  rem;
  logic [PROD_W-1:0] dvs;
  logic [REM_W-1:0]  diff;
  logic              ge;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  assign ge   = rem >= REM_W'(dvs);
  assign diff = ge ? rem - REM_W'(dvs) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // The first step yields the integer bit, the rest the fraction bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(num);
      dvs <= den;
    end else if (busy) begin
      rem <= diff << 1;
      quo <= {quo[PW-2:0], ge};
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// ----- rtl/bayesian_wall_detector.sv -----
// Bayesian wall detector: top level with the configuration registers, the
// four wall probabilities and the sequencer over the serial units.
// Depends on bwd_pkg, bwd_mul and bwd_div.
//
// Input items arrive on the s_axis channel: four distance readings and the
// heading. Each accepted item yields exactly one result item on m_axis: an
// absolute wall mask on tdata and, on tuser, a flag that says whether the
// mask is committed.
// The user is to write registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; checking this is left to the user.
// Direct mode goes from acceptance straight to S_EMIT, which moves the result
// into the output register once that register is free. In Bayesian mode the
// four probabilities are updated one after another, each by a bit-serial
// multiply of PROB_FRAC_BITS+1 steps and, unless the denominator is zero, a
// restoring division of as many steps, with S_LOAD and S_NEXT around each
// update and S_DECIDE before S_EMIT.
// One item is worked on at a time; the next is accepted as soon as the
// result has moved into the output register, even if it still waits there.
// If the receiver stalls with a result already held, the finished result
// waits in the sequencer until the output register frees.
// Reset is synchronous: registers take their defaults, the probabilities
// return to one half and no result is pending.
module bayesian_wall_detector #(
  parameter int PROB_FRAC_BITS = 16,
  parameter int DIST_BITS      = 12,
  localparam int PW    = PROB_FRAC_BITS + 1,
  localparam int CFG_W = (bwd_pkg::LIMIT_W > PW) ? bwd_pkg::LIMIT_W : PW,
  localparam int IN_TW = ((4 * DIST_BITS + 2 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_side_distance, right_side_distance, front_left_distance,
  // front_right_distance, heading
  input  logic [IN_TW-1:0]                s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // wall_mask
  output logic [7:0]                      m_axis_tdata,
  // mask_valid
  output logic                            m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [bwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]                cfg_data
);
  import bwd_pkg::*;

  localparam int PROD_W = 2 * PROB_FRAC_BITS + 1;
  localparam int CMP_W  = (DIST_BITS > LIMIT_W) ? DIST_BITS : LIMIT_W;
  localparam int D      = DIST_BITS;

  localparam logic [PW-1:0] PONE    = PW'(64'd1 << PROB_FRAC_BITS);
  localparam logic [PW-1:0] PHALF   = PW'(64'd1 << (PROB_FRAC_BITS - 1));
  localparam logic [PW-1:0] TENTH_9 = PW'(((64'd9 << PROB_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [PW-1:0] TENTH_2 = PW'(((64'd2 << PROB_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [PW-1:0] TENTH_1 = PW'(((64'd1 << PROB_FRAC_BITS) + 64'd5) / 64'd10);

  function automatic logic [PW-1:0] sat_one(input logic [PW-1:0] v);
    return (v > PONE) ? PONE : v;
  endfunction

  function automatic logic [3:0] build_mask(input logic [1:0] h, input logic l,
                                            input logic r, input logic f);
    logic [3:0] m;
    m = '0;
    m[h + 2'd3] = l;
    m[h + 2'd1] = r;
    m[h]        = f;
    return m;
  endfunction

  // Configuration registers
  logic                use_bayes;
  logic [LIMIT_W-1:0]  side_limit;
  logic [LIMIT_W-1:0]  front_limit;
  logic [PW-1:0]       hit_wall;
  logic [PW-1:0]       hit_open;
  logic [PW-1:0]       wall_conf;
  logic [PW-1:0]       open_conf;

  logic [PW-1:0]       prob [4];

  state_t              state;
  state_t              state_next;
  logic [1:0]          ch;
  logic [1:0]          heading;
  logic [3:0]          hits;
  logic [3:0]          res_mask;
  logic                res_valid;
  logic                m_valid;
  logic [7:0]          m_data;
  logic                m_user;

  logic                mul_start;
  logic                div_start;
  unit_status_t        mul_st;
  unit_status_t        div_st;
  logic [PROD_W-1:0]   mul_num;
  logic [PROD_W-1:0]   mul_den;
  logic [PW-1:0]       div_q;

  // Input fields
  logic [D-1:0]        in_ls;
  logic [D-1:0]        in_rs;
  logic [D-1:0]        in_fl;
  logic [D-1:0]        in_fr;
  logic [1:0]          in_heading;
  logic [3:0]          in_hits;
  logic [3:0]          direct_mask;

  assign in_ls      = s_axis_tdata[D-1:0];
  assign in_rs      = s_axis_tdata[2*D-1:D];
  assign in_fl      = s_axis_tdata[3*D-1:2*D];
  assign in_fr      = s_axis_tdata[4*D-1:3*D];
  assign in_heading = s_axis_tdata[4*D+1:4*D];

  assign in_hits[0] = CMP_W'(in_ls) < CMP_W'(side_limit);
  assign in_hits[1] = CMP_W'(in_rs) < CMP_W'(side_limit);
  assign in_hits[2] = CMP_W'(in_fl) < CMP_W'(front_limit);
  assign in_hits[3] = CMP_W'(in_fr) < CMP_W'(front_limit);

  assign direct_mask = build_mask(in_heading, in_hits[0], in_hits[1],
                                  in_hits[2] | in_hits[3]);

  // Operands of the current channel's update
  logic [PW-1:0] cur_p;
  logic [PW-1:0] lw_sat;
  logic [PW-1:0] lo_sat;
  logic [PW-1:0] lik_w;
  logic [PW-1:0] lik_o;

  assign cur_p  = sat_one(prob[ch]);
  assign lw_sat = sat_one(hit_wall);
  assign lo_sat = sat_one(hit_open);
  assign lik_w  = hits[ch] ? lw_sat : PONE - lw_sat;
  assign lik_o  = hits[ch] ? lo_sat : PONE - lo_sat;

  // Commit decision over the updated probabilities
  logic [3:0] conf;
  logic       all_conf;
  logic [3:0] bayes_mask;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      conf[i] = (prob[i] > wall_conf) || (prob[i] < open_conf);
    end
  end

  assign all_conf   = (&conf) && (prob[2] == prob[3]);
  assign bayes_mask = build_mask(heading, prob[0] > wall_conf, prob[1] > wall_conf,
                                 (prob[2] > wall_conf) && (prob[3] > wall_conf));

  bwd_mul #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .lik_a  (lik_w),
    .lik_b  (lik_o),
    .wt_a   (cur_p),
    .wt_b   (PONE - cur_p),
    .num    (mul_num),
    .den    (mul_den),
    .status (mul_st)
  );

  bwd_div #(.PROB_FRAC_BITS(PROB_FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (mul_num),
    .den    (mul_den),
    .quo    (div_q),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = use_bayes ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_st.done) begin
          // A zero denominator keeps the prior, so the division is skipped.
          if (mul_den == '0) begin
            state_next = S_NEXT;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        state_next = (ch == 2'd3) ? S_DECIDE : S_LOAD;
      end
      S_DECIDE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!m_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration, probabilities and the output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      use_bayes   <= 1'b1;
      side_limit  <= LIMIT_W'(90);
      front_limit <= LIMIT_W'(80);
      hit_wall    <= TENTH_9;
      hit_open    <= TENTH_2;
      wall_conf   <= TENTH_9;
      open_conf   <= TENTH_1;
      for (int i = 0; i < 4; i++) begin
        prob[i] <= PHALF;
      end
      m_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_USE_BAYES:      use_bayes   <= cfg_data[0];
          REG_SIDE_LIMIT:     side_limit  <= cfg_data[LIMIT_W-1:0];
          REG_FRONT_LIMIT:    front_limit <= cfg_data[LIMIT_W-1:0];
          REG_HIT_GIVEN_WALL: hit_wall    <= cfg_data[PW-1:0];
          REG_HIT_GIVEN_OPEN: hit_open    <= cfg_data[PW-1:0];
          REG_WALL_CONFIDENT: wall_conf   <= cfg_data[PW-1:0];
          REG_OPEN_CONFIDENT: open_conf   <= cfg_data[PW-1:0];
          default: ;
        endcase
      end
      if (state == S_DIV && div_st.done) begin
        prob[ch] <= div_q;
      end
      if (state == S_DECIDE && all_conf) begin
        for (int i = 0; i < 4; i++) begin
          prob[i] <= PHALF;
        end
      end
      if (state == S_EMIT && (!m_valid || m_axis_tready)) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Item payload and sequencing data
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          heading   <= in_heading;
          hits      <= in_hits;
          ch        <= 2'd0;
          res_mask  <= direct_mask;
          res_valid <= 1'b1;
        end
      end
      S_NEXT: begin
        if (ch != 2'd3) begin
          ch <= ch + 2'd1;
        end
      end
      S_DECIDE: begin
        res_valid <= all_conf;
        res_mask  <= all_conf ? bayes_mask : 4'd0;
      end
      S_EMIT: begin
        if (!m_valid || m_axis_tready) begin
          m_data <= {4'b0000, res_mask};
          m_user <= res_valid;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> state == S_MUL)
    else $error("multiplier finished outside its sequencer state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside its sequencer state");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> div_q <= PONE)
    else $error("updated probability exceeds one");

  a_decide_after_last: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> ch == 2'd3)
    else $error("decision reached before all four channels were updated");

  a_direct_to_emit: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !use_bayes) |=> state == S_EMIT)
    else $error("direct-mode item did not go straight to the result stage");

endmodule
